// ----- hw/rtl/eeg_pkg.sv -----
// ----------------------------------------------------------------------------
// eeg_pkg - shared types and constants for the extended gcd block
// Operand and field widths, and the control and status bundles that run
// between the round sequencer and the shared divide / multiply unit.
// ----------------------------------------------------------------------------
package eeg_pkg;

    // operand width (a, b, divisor field)
    localparam int OPER_WIDTH = 31;
    // width of each coefficient field on the result word
    localparam int COEF_FIELD_WIDTH = 32;
    // divide steps count from OPER_WIDTH-1 down to zero
    localparam int STEP_CNT_WIDTH = $clog2(OPER_WIDTH);

    // stream word widths, padded to whole bytes
    localparam int S_DATA_BITS  = 2 * OPER_WIDTH;
    localparam int S_TDATA_WIDTH = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = OPER_WIDTH + 2 * COEF_FIELD_WIDTH;
    localparam int M_TDATA_WIDTH = ((M_DATA_BITS + 7) / 8) * 8;

    // sequencer to divide unit
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // divide unit to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- hw/rtl/eeg_div_unit.sv -----
// ----------------------------------------------------------------------------
// eeg_div_unit - shared restoring divider with quotient-driven accumulators
// One quotient bit per cycle, msb first. Each quotient bit also steps two
// shift-add accumulators, so that q*xb and q*yb (modulo 2^DATA_WIDTH) are
// ready together with the remainder.
// ----------------------------------------------------------------------------
module eeg_div_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  eeg_pkg::div_ctrl_t              ctrl,
    output eeg_pkg::div_stat_t              stat,
    input  logic [eeg_pkg::OPER_WIDTH-1:0]  dividend,
    input  logic [eeg_pkg::OPER_WIDTH-1:0]  divisor,
    input  logic [DATA_WIDTH-1:0]           mul_x,
    input  logic [DATA_WIDTH-1:0]           mul_y,
    output logic [eeg_pkg::OPER_WIDTH-1:0]  remainder,
    output logic [DATA_WIDTH-1:0]           prod_x,
    output logic [DATA_WIDTH-1:0]           prod_y
);

    localparam int OW = eeg_pkg::OPER_WIDTH;
    localparam int CW = eeg_pkg::STEP_CNT_WIDTH;
    localparam logic [CW-1:0] LAST_STEP = CW'(OW - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [OW-1:0] rem_reg, rem_next;
    logic [OW-1:0] dvd_reg, dvd_next;
    logic [OW-1:0] dvs_reg, dvs_next;
    logic [DATA_WIDTH-1:0] mx_reg, mx_next;
    logic [DATA_WIDTH-1:0] my_reg, my_next;
    logic [DATA_WIDTH-1:0] accx_reg, accx_next;
    logic [DATA_WIDTH-1:0] accy_reg, accy_next;

    logic [OW:0]   shifted;
    logic [OW+1:0] diff;
    logic          qbit;

    // one trial subtract
    always_comb begin
        shifted = {rem_reg, dvd_reg[OW-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        qbit    = ~diff[OW+1];
    end

    // step sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        accx_next = accx_reg;
        accy_next = accy_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = LAST_STEP;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            mx_next   = mul_x;
            my_next   = mul_y;
            accx_next = '0;
            accy_next = '0;
        end else if (busy_reg) begin
            rem_next  = qbit ? diff[OW-1:0] : shifted[OW-1:0];
            dvd_next  = {dvd_reg[OW-2:0], 1'b0};
            accx_next = {accx_reg[DATA_WIDTH-2:0], 1'b0} + (qbit ? mx_reg : '0);
            accy_next = {accy_reg[DATA_WIDTH-2:0], 1'b0} + (qbit ? my_reg : '0);
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        accx_reg <= accx_next;
        accy_reg <= accy_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;
    assign prod_x    = accx_reg;
    assign prod_y    = accy_reg;

endmodule

// ----- hw/rtl/extended_euclid_gcd_top.sv -----
// ----------------------------------------------------------------------------
// extended_euclid_gcd_top - greatest common divisor with Bezout coefficients
// Runs the iterative extended Euclidean algorithm on one operand pair at a
// time, one round per pass through the shared divide / multiply unit.
//
//   channel  dir  word fields (lsb up)                       handshake
//   s_       in   value_a[31], value_b[31], pad              tvalid/tready
//   m_       out  divisor[31], coef_a[32], coef_b[32], pad   tvalid/tready
//
// One round is a start, 31 divide steps and a coefficient update. An item
// needs up to 45 rounds for 31-bit operands; the one-bit-per-cycle divider
// dominates the time each item takes.
// The input is ready only while no item is in work; a finished result waits
// in the output register while the next item is taken in.
// Reset is synchronous, active low, and clears only control state.
// ----------------------------------------------------------------------------
module extended_euclid_gcd_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // value_a[30:0], value_b[61:31], zero pad
    input  logic [eeg_pkg::S_TDATA_WIDTH-1:0]  s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // divisor[30:0], coef_a[62:31], coef_b[94:63], zero pad
    output logic [eeg_pkg::M_TDATA_WIDTH-1:0]  m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    localparam int OW = eeg_pkg::OPER_WIDTH;
    localparam int FW = eeg_pkg::COEF_FIELD_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV
    } state_t;

    state_t state_reg, state_next;
    logic [OW-1:0] a_reg, a_next;
    logic [OW-1:0] b_reg, b_next;
    logic [DATA_WIDTH-1:0] xa_reg, xa_next, xb_reg, xb_next;
    logic [DATA_WIDTH-1:0] ya_reg, ya_next, yb_reg, yb_next;
    logic out_valid_reg, out_valid_next;
    logic [eeg_pkg::M_TDATA_WIDTH-1:0] out_data_reg, out_data_next;

    eeg_pkg::div_ctrl_t div_ctrl;
    eeg_pkg::div_stat_t div_stat;
    logic [OW-1:0]         div_rem;
    logic [DATA_WIDTH-1:0] prod_x, prod_y;
    logic [FW-1:0]         coef_a_out, coef_b_out;
    logic                  in_take, out_take;

    assign in_take  = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;

    // shared divide / multiply unit
    eeg_div_unit #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .stat      (div_stat),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .mul_x     (xb_reg),
        .mul_y     (yb_reg),
        .remainder (div_rem),
        .prod_x    (prod_x),
        .prod_y    (prod_y)
    );

    // coefficients onto the 32-bit fields
    generate
        if (DATA_WIDTH >= FW) begin : g_coef_trunc
            assign coef_a_out = xa_reg[FW-1:0];
            assign coef_b_out = ya_reg[FW-1:0];
        end else begin : g_coef_ext
            assign coef_a_out = {{(FW-DATA_WIDTH){1'b0}}, xa_reg};
            assign coef_b_out = {{(FW-DATA_WIDTH){1'b0}}, ya_reg};
        end
    endgenerate

    // round sequencer
    always_comb begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        xa_next        = xa_reg;
        xb_next        = xb_reg;
        ya_next        = ya_reg;
        yb_next        = yb_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;
        div_ctrl.start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    a_next     = s_tdata[OW-1:0];
                    b_next     = s_tdata[2*OW-1:OW];
                    xa_next    = DATA_WIDTH'(1);
                    xb_next    = '0;
                    ya_next    = '0;
                    yb_next    = DATA_WIDTH'(1);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (b_reg != '0) begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end else if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = eeg_pkg::M_TDATA_WIDTH'({coef_b_out, coef_a_out, a_reg});
                    state_next     = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    a_next     = b_reg;
                    b_next     = div_rem;
                    xa_next    = xb_reg;
                    xb_next    = xa_reg - prod_x;
                    ya_next    = yb_reg;
                    yb_next    = ya_reg - prod_y;
                    state_next = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        a_reg        <= a_next;
        b_reg        <= b_next;
        xa_reg       <= xa_next;
        xb_reg       <= xb_next;
        ya_reg       <= ya_next;
        yb_reg       <= yb_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // divider is started only from the check step with a nonzero divisor
    a_start_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctrl.start |-> (state_reg == ST_CHECK) && (b_reg != '0))
        else $error("divide started outside check step");

    // never restart the divider while it is stepping
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctrl.start |-> !div_stat.busy && !div_stat.done)
        else $error("divide started while busy");

    // a finished divide is only seen while waiting for it
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divide finished outside divide step");

    // an accepted word goes straight to the check step
    a_take_check: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> (state_reg == ST_CHECK))
        else $error("accepted word not checked");

    // a waiting result is never overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("pending result lost");

endmodule

// ----- dv/extended_euclid_gcd_top_tb.sv -----
// ----------------------------------------------------------------------------
// extended_euclid_gcd_top_tb - self-checking bench for the extended gcd block
// Sends operand pairs on the input stream and checks every result word
// (divisor and both Bezout coefficients) against an in-bench iterative
// Euclid predictor, in order. Corner pairs come first, then a gap-free burst,
// then a long output hold-off while the input keeps offering words, and
// last a mix of random pairs of several shapes. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module extended_euclid_gcd_top_tb;

    // coefficient register width of the instance
    localparam int COEF_DW = 32;
    // receiver hold-off length for the backpressure test
    localparam int HOLD_CYCLES = 4000;
    // idle cycles with no handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT = 30000;
    // settle time after the last result, about one worst-case item
    localparam int DRAIN_CYCLES = 1600;
    // consecutive fibonacci numbers, the worst case for round count
    localparam logic [eeg_pkg::OPER_WIDTH-1:0] FIB_46 = 31'd1836311903;
    localparam logic [eeg_pkg::OPER_WIDTH-1:0] FIB_45 = 31'd1134903170;
    localparam logic [eeg_pkg::OPER_WIDTH-1:0] OPER_MAX = {eeg_pkg::OPER_WIDTH{1'b1}};

    typedef struct packed {
        logic [eeg_pkg::OPER_WIDTH-1:0]       divisor;
        logic [eeg_pkg::COEF_FIELD_WIDTH-1:0] coef_a;
        logic [eeg_pkg::COEF_FIELD_WIDTH-1:0] coef_b;
    } gcd_result_t;

    logic                              aclk;
    logic                              aresetn;
    logic [eeg_pkg::S_TDATA_WIDTH-1:0] s_tdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [eeg_pkg::M_TDATA_WIDTH-1:0] m_tdata;
    logic                              m_tvalid;
    logic                              m_tready;

    gcd_result_t pending_gcd_q[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    bit          no_idle = 1'b0;
    bit          hold_output = 1'b0;

    extended_euclid_gcd_top #(
        .DATA_WIDTH(COEF_DW)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // iterative extended euclid, coefficients wrap at the register width
    function automatic gcd_result_t predict_gcd(
            input logic [eeg_pkg::OPER_WIDTH-1:0] a_in,
            input logic [eeg_pkg::OPER_WIDTH-1:0] b_in);
        logic [63:0] rem_a, rem_b, quot, tmp, cmask;
        logic [63:0] xa, xb, ya, yb;
        gcd_result_t res;
        cmask = (COEF_DW >= 64) ? {64{1'b1}} : ((64'd1 << COEF_DW) - 64'd1);
        rem_a = 64'(a_in);
        rem_b = 64'(b_in);
        xa = 64'd1;
        xb = 64'd0;
        ya = 64'd0;
        yb = 64'd1;
        while (rem_b != 64'd0) begin
            quot  = rem_a / rem_b;
            tmp   = rem_a % rem_b;
            rem_a = rem_b;
            rem_b = tmp;
            tmp = (xa - quot * xb) & cmask;
            xa  = xb;
            xb  = tmp;
            tmp = (ya - quot * yb) & cmask;
            ya  = yb;
            yb  = tmp;
        end
        res.divisor = rem_a[eeg_pkg::OPER_WIDTH-1:0];
        res.coef_a  = xa[eeg_pkg::COEF_FIELD_WIDTH-1:0];
        res.coef_b  = ya[eeg_pkg::COEF_FIELD_WIDTH-1:0];
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int pick;
        if (no_idle)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // operand of random bit length, so small values show up often
    function automatic logic [eeg_pkg::OPER_WIDTH-1:0] random_operand();
        int nbits;
        logic [31:0] raw;
        nbits = $urandom_range(1, eeg_pkg::OPER_WIDTH);
        raw = $urandom;
        return eeg_pkg::OPER_WIDTH'(raw & ((32'd1 << nbits) - 32'd1));
    endfunction

    // offer one operand word, record the expected result once taken
    task automatic send_operands(input logic [eeg_pkg::OPER_WIDTH-1:0] a_val,
                                 input logic [eeg_pkg::OPER_WIDTH-1:0] b_val);
        logic [eeg_pkg::S_TDATA_WIDTH-1:0] word;
        int gap;
        word = '0;
        word[eeg_pkg::OPER_WIDTH-1:0] = a_val;
        word[2*eeg_pkg::OPER_WIDTH-1:eeg_pkg::OPER_WIDTH] = b_val;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_gcd_q.push_back(predict_gcd(a_val, b_val));
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // zeros, extremes, worst-case round count and the early-exit cases
    task automatic test_corner_pairs();
        send_operands(31'd0, 31'd0);
        send_operands(OPER_MAX, 31'd0);
        send_operands(31'd1, 31'd0);
        send_operands(31'd0, OPER_MAX);
        send_operands(31'd0, 31'd1);
        send_operands(31'd1, 31'd1);
        send_operands(OPER_MAX, OPER_MAX);
        send_operands(OPER_MAX, 31'd1);
        send_operands(31'd1, OPER_MAX);
        send_operands(OPER_MAX, OPER_MAX - 31'd1);
        send_operands(OPER_MAX - 31'd1, OPER_MAX);
        send_operands(FIB_46, FIB_45);
        send_operands(FIB_45, FIB_46);
        send_operands(31'd89, 31'd55);
        send_operands(31'h4000_0000, 31'h2000_0000);
        send_operands(31'h2AAA_AAAA, 31'h5555_5555);
        send_operands(31'd6, 31'd4);
        send_operands(31'd240, 31'd46);
        send_operands(31'd17, 31'd17);
        send_operands(31'd1000, 31'd7);
    endtask

    // back-to-back words with both sides always ready
    task automatic test_gap_free_burst();
        int idx;
        no_idle = 1'b1;
        for (idx = 0; idx < 20; idx++)
            send_operands(random_operand(), random_operand());
        no_idle = 1'b0;
    endtask

    // receiver stalls long while the sender keeps offering full-width pairs
    task automatic test_output_holdoff();
        int idx;
        hold_output = 1'b1;
        for (idx = 0; idx < 6; idx++)
            send_operands(eeg_pkg::OPER_WIDTH'($urandom), eeg_pkg::OPER_WIDTH'($urandom));
    endtask

    // random pairs of several shapes
    task automatic test_random_pairs(input int count);
        int idx;
        int shape;
        logic [eeg_pkg::OPER_WIDTH-1:0] a_val, b_val, factor;
        for (idx = 0; idx < count; idx++) begin
            shape = $urandom_range(0, 9);
            case (shape)
                0, 1, 2, 3: begin
                    a_val = eeg_pkg::OPER_WIDTH'($urandom);
                    b_val = eeg_pkg::OPER_WIDTH'($urandom);
                end
                4, 5: begin
                    a_val = random_operand();
                    b_val = random_operand();
                end
                6: begin
                    // one operand zero
                    a_val = $urandom_range(0, 1) ? eeg_pkg::OPER_WIDTH'($urandom) : '0;
                    b_val = (a_val == '0) ? eeg_pkg::OPER_WIDTH'($urandom) : '0;
                end
                7: begin
                    // exact multiple
                    b_val = eeg_pkg::OPER_WIDTH'($urandom_range(1, 32767));
                    a_val = b_val * eeg_pkg::OPER_WIDTH'($urandom_range(1, 65535));
                    if ($urandom_range(0, 1))
                        {a_val, b_val} = {b_val, a_val};
                end
                default: begin
                    // common factor from 2 to 1000
                    factor = eeg_pkg::OPER_WIDTH'($urandom_range(2, 1000));
                    a_val = factor * eeg_pkg::OPER_WIDTH'($urandom_range(1, 1048575));
                    b_val = factor * eeg_pkg::OPER_WIDTH'($urandom_range(1, 1048575));
                end
            endcase
            send_operands(a_val, b_val);
        end
    endtask

    // result side ready, with random stalls and the requested hold-off
    initial begin : result_ready_gen
        int stall;
        m_tready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
            end else begin
                stall = idle_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // compare each result word with the oldest expected result
    always @(posedge aclk) begin : result_check
        gcd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_gcd_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                want = pending_gcd_q.pop_front();
                check_field("divisor", 32'(want.divisor),
                            32'(m_tdata[eeg_pkg::OPER_WIDTH-1:0]));
                check_field("coef_a", want.coef_a,
                            m_tdata[eeg_pkg::OPER_WIDTH +: eeg_pkg::COEF_FIELD_WIDTH]);
                check_field("coef_b", want.coef_b,
                            m_tdata[eeg_pkg::OPER_WIDTH+eeg_pkg::COEF_FIELD_WIDTH
                                    +: eeg_pkg::COEF_FIELD_WIDTH]);
            end
        end
    end

    // hang detection: too long without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // reset, test sequence, drain and verdict
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_corner_pairs();
        test_gap_free_burst();
        test_output_holdoff();
        test_random_pairs(354);

        s_tvalid <= 1'b0;
        while (pending_gcd_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- extended_euclid_gcd_top.f -----
hw/rtl/eeg_pkg.sv
hw/rtl/eeg_div_unit.sv
hw/rtl/extended_euclid_gcd_top.sv
dv/extended_euclid_gcd_top_tb.sv
